FILE: hw/rtl/mie_pkg.sv
// shared widths, types and divider control structs for the modular inverse block
`default_nettype none
package mie_pkg;

   // operand width and derived widths
   localparam int DATA_WIDTH = 31;
   localparam int COEF_WIDTH = DATA_WIDTH + 1;
   localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [COEF_WIDTH-1:0] coef_type;
   typedef logic [CNT_WIDTH-1:0]  cnt_type;

   localparam cnt_type  CNT_LAST = CNT_WIDTH'(DATA_WIDTH - 1);
   localparam data_type DATA_ONE = DATA_WIDTH'(1);
   localparam coef_type COEF_ONE = COEF_WIDTH'(1);

   // command to the shared divide / multiply-accumulate unit
   typedef struct packed {
      logic     start;
      data_type dividend;
      data_type divisor;
      coef_type mult;
   } div_cmd_type;

   // result of the shared unit, valid while done is high
   typedef struct packed {
      logic     done;
      data_type rem;
      coef_type prod;
   } div_rsp_type;

endpackage
`default_nettype wire

FILE: hw/rtl/mie_req_if.sv
// request channel: value and modulus with valid/ready
`default_nettype none
interface mie_req_if;
   logic               valid;
   logic               ready;
   mie_pkg::data_type  value;
   mie_pkg::data_type  modulus;

   modport source (output valid, output value, output modulus, input ready);
   modport sink   (input valid, input value, input modulus, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mie_rsp_if.sv
// response channel: inverse and found flag with valid/ready
`default_nettype none
interface mie_rsp_if;
   logic               valid;
   logic               ready;
   mie_pkg::data_type  inverse;
   logic               found;

   modport source (output valid, output inverse, output found, input ready);
   modport sink   (input valid, input inverse, input found, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/modular_inverse_ext_euclid.sv
// modular inverse by extended euclid around one shared divide / multiply unit
// one request at a time: req ready only while idle, so a new request waits for the response to be taken
// modulus 0 or 1 answers in the cycle after the beat, a zero reduced value once the reduction divide is done
// reset: synchronous, clears the sequencer and the response valid; datapath registers are not reset
`default_nettype none
module modular_inverse_ext_euclid (
   input  wire        clock,
   input  wire        reset,
   mie_req_if.sink    req_bus,
   mie_rsp_if.source  rsp_bus
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_NEXT,
      S_DIVIDE,
      S_WRAP,
      S_NORM,
      S_RESPOND
   } state_type;

   state_type              state_ff, state_in;
   mie_pkg::data_type      m_ff, m_in;
   mie_pkg::data_type      r0_ff, r0_in;
   mie_pkg::data_type      r1_ff, r1_in;
   mie_pkg::coef_type      t0_ff, t0_in;
   mie_pkg::coef_type      t1_ff, t1_in;
   mie_pkg::data_type      inverse_ff, inverse_in;
   logic                   found_ff, found_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   mie_pkg::div_cmd_type   div_cmd;
   mie_pkg::div_rsp_type   div_rsp;
   logic                   req_beat;
   mie_pkg::coef_type      m_ext;

   assign req_beat = req_bus.valid && (state_ff == S_IDLE);
   assign m_ext    = {1'b0, m_ff};

   // shared divider
   mie_div_unit u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // divider launch: reduce on a request beat with modulus above one, one euclid step from S_NEXT
   always_comb begin
      div_cmd = '0;
      if (req_beat && (req_bus.modulus > mie_pkg::DATA_ONE)) begin
         div_cmd.start    = 1'b1;
         div_cmd.dividend = req_bus.value;
         div_cmd.divisor  = req_bus.modulus;
         div_cmd.mult     = '0;
      end else if ((state_ff == S_NEXT) && (r1_ff != '0)) begin
         div_cmd.start    = 1'b1;
         div_cmd.dividend = r0_ff;
         div_cmd.divisor  = r1_ff;
         div_cmd.mult     = t1_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      inverse_in   = inverse_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               m_in       = req_bus.modulus;
               inverse_in = '0;
               found_in   = 1'b0;
               if (req_bus.modulus == '0) begin
                  state_in     = S_RESPOND;
                  rsp_valid_in = 1'b1;
               end else if (req_bus.modulus == mie_pkg::DATA_ONE) begin
                  found_in     = 1'b1;
                  state_in     = S_RESPOND;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = S_REDUCE;
               end
            end
         end
         S_REDUCE: begin
            if (div_rsp.done) begin
               if (div_rsp.rem == '0) begin
                  state_in     = S_RESPOND;
                  rsp_valid_in = 1'b1;
               end else begin
                  r0_in    = m_ff;
                  r1_in    = div_rsp.rem;
                  t0_in    = '0;
                  t1_in    = mie_pkg::COEF_ONE;
                  state_in = S_NEXT;
               end
            end
         end
         S_NEXT: begin
            if (r1_ff != '0) begin
               state_in = S_DIVIDE;
            end else if (r0_ff != mie_pkg::DATA_ONE) begin
               state_in     = S_RESPOND;
               rsp_valid_in = 1'b1;
            end else begin
               state_in = S_WRAP;
            end
         end
         S_DIVIDE: begin
            // r2 = r0 mod r1, t2 = t0 - q*t1
            if (div_rsp.done) begin
               r0_in    = r1_ff;
               r1_in    = div_rsp.rem;
               t0_in    = t1_ff;
               t1_in    = t0_ff - div_rsp.prod;
               state_in = S_NEXT;
            end
         end
         S_WRAP: begin
            // negative coefficient moves up by the modulus
            if (t0_ff[mie_pkg::COEF_WIDTH-1]) begin
               t0_in = t0_ff + m_ext;
            end
            state_in = S_NORM;
         end
         S_NORM: begin
            inverse_in   = (t0_ff >= m_ext) ? mie_pkg::data_type'(t0_ff - m_ext)
                                            : t0_ff[mie_pkg::DATA_WIDTH-1:0];
            found_in     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_RESPOND;
         end
         S_RESPOND: begin
            if (rsp_bus.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      m_ff       <= m_in;
      r0_ff      <= r0_in;
      r1_ff      <= r1_in;
      t0_ff      <= t0_in;
      t1_ff      <= t1_in;
      inverse_ff <= inverse_in;
      found_ff   <= found_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // channel outputs
   assign req_bus.ready   = (state_ff == S_IDLE);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.inverse = inverse_ff;
   assign rsp_bus.found   = found_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/mie_div_unit.sv
// radix-2 restoring divider that also accumulates quotient times a coefficient
`default_nettype none
module mie_div_unit (
   input  wire                    clock,
   input  wire                    reset,
   input  mie_pkg::div_cmd_type   cmd,
   output mie_pkg::div_rsp_type   rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   mie_pkg::cnt_type              cnt_ff, cnt_in;
   mie_pkg::data_type             dvd_ff, dvd_in;
   mie_pkg::data_type             dsr_ff, dsr_in;
   mie_pkg::data_type             rem_ff, rem_in;
   mie_pkg::coef_type             mult_ff, mult_in;
   mie_pkg::coef_type             acc_ff, acc_in;

   logic [mie_pkg::DATA_WIDTH:0]  rem_sh;
   logic [mie_pkg::DATA_WIDTH:0]  diff;
   logic                          qbit;
   mie_pkg::coef_type             acc_sh;

   // one quotient bit per cycle, msb first
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[mie_pkg::DATA_WIDTH-1]};
      diff   = rem_sh - {1'b0, dsr_ff};
      qbit   = (rem_sh >= {1'b0, dsr_ff});
      acc_sh = {acc_ff[mie_pkg::COEF_WIDTH-2:0], 1'b0} + (qbit ? mult_ff : '0);
   end

   // next state
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      mult_in = mult_ff;
      acc_in  = acc_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = mie_pkg::CNT_LAST;
         dvd_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
         mult_in = cmd.mult;
         rem_in  = '0;
         acc_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[mie_pkg::DATA_WIDTH-2:0], 1'b0};
         rem_in = qbit ? diff[mie_pkg::DATA_WIDTH-1:0] : rem_sh[mie_pkg::DATA_WIDTH-1:0];
         acc_in = acc_sh;
         cnt_in = cnt_ff - mie_pkg::cnt_type'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      rem_ff  <= rem_in;
      mult_ff <= mult_in;
      acc_ff  <= acc_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;
   assign rsp.prod = acc_ff;

endmodule
`default_nettype wire
